// File: sv/bdv_pkg.sv
`timescale 1ns / 1ps

package bdv_pkg;

  // Field widths of the input and result beats
  localparam int unsigned MANT_LO_W = 64;
  localparam int unsigned MANT_HI_W = 32;
  localparam int unsigned MANT_W    = MANT_LO_W + MANT_HI_W;
  localparam int unsigned SCALE_W   = 5;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned DIGIT_W   = 4;

  // Largest scale; 29..31 saturate to this
  localparam logic [SCALE_W-1:0] MAX_SCALE = SCALE_W'(28);

  // Default digit count; 29 digits cover the full 96-bit range
  localparam int unsigned NUM_DIGITS_DEF = 29;

  // Double-dabble split: shift/add-3 steps per register stage
  localparam int unsigned STEPS_PER_STAGE = 8;
  localparam int unsigned NUM_STAGES      = MANT_W / STEPS_PER_STAGE;

  // Side information that travels with each value down the pipe
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic               negative;
  } meta_t;

endpackage

// File: sv/bdv_in_if.sv
`timescale 1ns / 1ps

interface bdv_in_if import bdv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MANT_LO_W-1:0] mantissa_low;
  logic [MANT_HI_W-1:0] mantissa_high;
  logic [SCALE_W-1:0]   scale;
  logic                 negative;

  modport source (
    output valid, mantissa_low, mantissa_high, scale, negative,
    input  ready
  );
  modport sink (
    input  valid, mantissa_low, mantissa_high, scale, negative,
    output ready
  );
endinterface

// File: sv/bdv_out_if.sv
`timescale 1ns / 1ps

interface bdv_out_if import bdv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  digit_position;
  logic [DIGIT_W-1:0]       digit_value;
  logic                     value_negative;
  logic                     last_digit;

  modport source (
    output valid, digit_position, digit_value, value_negative, last_digit,
    input  ready
  );
  modport sink (
    input  valid, digit_position, digit_value, value_negative, last_digit,
    output ready
  );
endinterface

// File: sv/bdv_dd_stage.sv
`timescale 1ns / 1ps

module bdv_dd_stage import bdv_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [MANT_W-1:0]            bin_i,
  input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  input  meta_t                        meta_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [MANT_W-1:0]            bin_o,
  output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_o,
  output meta_t                        meta_o
);

  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;

  logic              valid_q;
  logic [MANT_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  meta_t             meta_q;

  // Stage holds a beat until the next stage takes it
  assign ready_o = !valid_q || ready_i;

  // Shift/add-3 steps; digits above the top are dropped, lower ones stay exact
  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_d[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
          bcd_d[d*DIGIT_W +: DIGIT_W] = bcd_d[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], bin_d[MANT_W-1]};
      bin_d = {bin_d[MANT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      bin_q  <= bin_d;
      bcd_q  <= bcd_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;
  assign meta_o  = meta_q;

endmodule

// File: sv/bdv_serializer.sv
`timescale 1ns / 1ps

module bdv_serializer import bdv_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  input  meta_t                         meta_i,
  bdv_out_if.source                     out_o
);

  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int unsigned IDX_W = $clog2(NUM_DIGITS);

  logic                    busy_q;
  logic [IDX_W-1:0]        idx_q;
  logic [BCD_W-1:0]        digits_q;
  logic signed [POS_W-1:0] pos_q;
  logic                    neg_q;
  logic                    last;
  logic                    load;
  logic                    beat;

  assign last  = (idx_q == IDX_W'(NUM_DIGITS - 1));
  assign beat  = busy_q && out_o.ready;
  // Next run loads in the same cycle the final digit leaves
  assign ready_o = !busy_q || (out_o.ready && last);
  assign load  = valid_i && ready_o;

  // Run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (beat) begin
      if (last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  // Digit shift line and position counter
  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= bcd_i;
      pos_q    <= POS_W'(0) - POS_W'(meta_i.scale);
      neg_q    <= meta_i.negative;
    end else if (beat) begin
      digits_q <= {{DIGIT_W{1'b0}}, digits_q[BCD_W-1:DIGIT_W]};
      pos_q    <= pos_q + POS_W'(1);
    end
  end

  assign out_o.valid          = busy_q;
  assign out_o.digit_position = pos_q;
  assign out_o.digit_value    = digits_q[DIGIT_W-1:0];
  assign out_o.value_negative = neg_q;
  assign out_o.last_digit     = last;

endmodule

// File: sv/binary_decimal_to_digit_vector.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// in_i     in   mantissa_low[64], mantissa_high[32], scale[5], negative
// out_o    out  digit_position[6 signed], digit_value[4], value_negative, last_digit
//
// Each value gives NUM_DIGITS result beats, least significant digit first.
// Conversion is a 12-stage double-dabble pipe, 8 bits per stage, followed by the
// serializer register that drives out_o.
// Sustained rate is set by the one-digit-per-beat result channel; the next value
// loads as the final digit of the previous one leaves.
// Reset clears all stage valid bits and the digit counter.
// Each stage stalls on its own ready; beats are held, never dropped or repeated.

module binary_decimal_to_digit_vector import bdv_pkg::*; #(
  parameter int unsigned NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdv_in_if.sink    in_i,
  bdv_out_if.source out_o
);

  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;

  logic              valid_s [NUM_STAGES+1];
  logic              ready_s [NUM_STAGES+1];
  logic [MANT_W-1:0] bin_s   [NUM_STAGES+1];
  logic [BCD_W-1:0]  bcd_s   [NUM_STAGES+1];
  meta_t             meta_s  [NUM_STAGES+1];

  // Pipe entry: scale saturates here
  assign valid_s[0]           = in_i.valid;
  assign in_i.ready           = ready_s[0];
  assign bin_s[0]             = {in_i.mantissa_high, in_i.mantissa_low};
  assign bcd_s[0]             = '0;
  assign meta_s[0].scale      = (in_i.scale > MAX_SCALE) ? MAX_SCALE : in_i.scale;
  assign meta_s[0].negative   = in_i.negative;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    bdv_dd_stage #(
      .NUM_DIGITS (NUM_DIGITS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .bin_i   (bin_s[g]),
      .bcd_i   (bcd_s[g]),
      .meta_i  (meta_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .bin_o   (bin_s[g+1]),
      .bcd_o   (bcd_s[g+1]),
      .meta_o  (meta_s[g+1])
    );
  end

  // Digit emitter
  bdv_serializer #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[NUM_STAGES]),
    .ready_o (ready_s[NUM_STAGES]),
    .bcd_i   (bcd_s[NUM_STAGES]),
    .meta_i  (meta_s[NUM_STAGES]),
    .out_o   (out_o)
  );

endmodule

// File: sv/bdv_checker.sv
`timescale 1ns / 1ps

module bdv_checker import bdv_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [POS_W-1:0] digit_position_i,
  input logic [DIGIT_W-1:0]      digit_value_i,
  input logic                    value_negative_i,
  input logic                    last_digit_i
);

  logic mid_beat;
  assign mid_beat = out_valid_i && out_ready_i && !last_digit_i;

  // Every digit is decimal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_value_i <= DIGIT_W'(9))
    else $error("digit out of decimal range");

  // A run continues without a gap, one place higher each beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_beat |=> out_valid_i && (digit_position_i == $past(digit_position_i) + POS_W'(1)))
    else $error("digit run broken or position not incrementing");

  // Sign holds for the whole run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_beat |=> value_negative_i == $past(value_negative_i))
    else $error("sign changed inside a run");

  // Position stays within the scale range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (digit_position_i >= -POS_W'(28)) && (digit_position_i <= POS_W'(28)))
    else $error("digit position out of range");

  // A stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digit_position_i)
      && $stable(digit_value_i) && $stable(last_digit_i))
    else $error("stalled beat changed");

endmodule

bind binary_decimal_to_digit_vector bdv_checker u_bdv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .digit_position_i (out_o.digit_position),
  .digit_value_i    (out_o.digit_value),
  .value_negative_i (out_o.value_negative),
  .last_digit_i     (out_o.last_digit)
);
